>>> sv/cce_pkg.sv
`timescale 1ns / 1ps

package cce_pkg;

  // crc width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_CODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLY_VALUE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_VALUE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_XOR_MASK  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_IN    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_OUT   = 3'd5;

  // reset configuration
  localparam logic [1:0]  RESET_WIDTH_CODE  = WIDTH_32;
  localparam logic [31:0] RESET_POLY        = 32'h04C1_1DB7;
  localparam logic [31:0] RESET_START       = 32'hFFFF_FFFF;
  localparam logic [31:0] RESET_XOR         = 32'hFFFF_FFFF;
  localparam logic        RESET_REFLECT_IN  = 1'b1;
  localparam logic        RESET_REFLECT_OUT = 1'b1;

  // mask of the active crc bits; the unused code acts as 32 bits
  function automatic logic [31:0] width_mask(logic [1:0] code);
    logic [31:0] m;
    case (code)
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] rev8(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [31:0] rev32(logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  // fold one byte into the register: xor into top byte, eight shift-xor steps
  function automatic logic [31:0] fold_byte(logic [31:0] crc, logic [7:0] b,
                                            logic [1:0] code, logic [31:0] poly);
    logic [31:0] m;
    logic [31:0] p;
    logic [31:0] r;
    logic        top;
    m = width_mask(code);
    p = poly & m;
    r = crc & m;
    case (code)
      WIDTH_8:  r[7:0]   = r[7:0] ^ b;
      WIDTH_16: r[15:8]  = r[15:8] ^ b;
      default:  r[31:24] = r[31:24] ^ b;
    endcase
    for (int i = 0; i < 8; i++) begin
      case (code)
        WIDTH_8:  top = r[7];
        WIDTH_16: top = r[15];
        default:  top = r[31];
      endcase
      r = top ? (((r << 1) ^ p) & m) : ((r << 1) & m);
    end
    return r;
  endfunction

  // finished value: optional reversal over the width, then final xor
  function automatic logic [31:0] finish_crc(logic [31:0] crc, logic [1:0] code,
                                             logic reflect, logic [31:0] xmask);
    logic [31:0] r;
    r = crc;
    if (reflect) begin
      case (code)
        WIDTH_8:  r = {24'd0, rev8(crc[7:0])};
        WIDTH_16: r = {16'd0, rev8(crc[7:0]), rev8(crc[15:8])};
        default:  r = rev32(crc);
      endcase
    end
    return (r ^ xmask) & width_mask(code);
  endfunction

endpackage

>>> sv/configurable_crc_engine_top.sv
`timescale 1ns / 1ps

// channel  | ports                                        | direction
// input    | in_valid in_ready in_data_byte in_first_byte | in, one message byte per transfer
//          | in_last_byte                                 |
// result   | out_valid out_ready out_crc_out              | out, one crc per input byte
//          | out_final_mark                               |
// config   | cfg_we cfg_index cfg_wdata                   | in, single cycle write
//
// one byte per cycle while the output is not stalled; the result of a byte is in the output
// register in the cycle after its transfer. the eight shift-xor steps sit in combinational
// logic between the crc register and the output register. synchronous active-low reset
// restores the default crc-32 setup. a stalled output holds its result, and a new byte is
// taken in the cycle the waiting result leaves.

module configurable_crc_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_crc_out,
  output logic        out_final_mark,
  input  logic        cfg_we,
  input  logic [cce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [1:0]  width_code_r;
  logic [31:0] poly_value_r;
  logic [31:0] start_value_r;
  logic [31:0] out_xor_mask_r;
  logic        reflect_in_r;
  logic        reflect_out_r;

  logic [31:0] crc_r, crc_nxt;
  logic        out_valid_r;
  logic [31:0] out_crc_r, out_crc_nxt;
  logic        out_final_r;

  logic        in_xfer;
  logic [31:0] crc_base;
  logic [7:0]  byte_in;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_code_r   <= cce_pkg::RESET_WIDTH_CODE;
      poly_value_r   <= cce_pkg::RESET_POLY;
      start_value_r  <= cce_pkg::RESET_START;
      out_xor_mask_r <= cce_pkg::RESET_XOR;
      reflect_in_r   <= cce_pkg::RESET_REFLECT_IN;
      reflect_out_r  <= cce_pkg::RESET_REFLECT_OUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cce_pkg::REG_WIDTH_CODE:   width_code_r   <= cfg_wdata[1:0];
        cce_pkg::REG_POLY_VALUE:   poly_value_r   <= cfg_wdata;
        cce_pkg::REG_START_VALUE:  start_value_r  <= cfg_wdata;
        cce_pkg::REG_OUT_XOR_MASK: out_xor_mask_r <= cfg_wdata;
        cce_pkg::REG_REFLECT_IN:   reflect_in_r   <= cfg_wdata[0];
        cce_pkg::REG_REFLECT_OUT:  reflect_out_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // output register frees up when empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // crc datapath
  always_comb begin
    crc_base    = in_first_byte ? start_value_r : crc_r;
    byte_in     = reflect_in_r ? cce_pkg::rev8(in_data_byte) : in_data_byte;
    crc_nxt     = cce_pkg::fold_byte(crc_base, byte_in, width_code_r, poly_value_r);
    out_crc_nxt = cce_pkg::finish_crc(crc_nxt, width_code_r, reflect_out_r,
                                      out_xor_mask_r);
  end

  // running crc and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= cce_pkg::RESET_START & cce_pkg::width_mask(cce_pkg::RESET_WIDTH_CODE);
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        crc_r <= crc_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_crc_r   <= out_crc_nxt;
      out_final_r <= in_last_byte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_crc_out    = out_crc_r;
  assign out_final_mark = out_final_r;

endmodule

>>> sv/cce_checker.sv
`timescale 1ns / 1ps

module cce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_crc_out,
  input logic        out_final_mark
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_crc_out) && $stable(out_final_mark))
    else $error("result payload changed while stalled");

  // every input transfer shows its result in the next cycle with its last flag
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && (out_final_mark == $past(in_last_byte)))
    else $error("input transfer produced no result");

  // input side is blocked only by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output register");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind configurable_crc_engine_top cce_checker u_cce_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // indexes past the register list; writes there must be ignored
  localparam logic [cce_pkg::CFG_INDEX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [cce_pkg::CFG_INDEX_W-1:0] REG_UNUSED_B = 3'd7;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_SET  = 62;

  typedef struct packed {
    logic [31:0] crc;
    logic        mark;
  } crc_result_t;

  // running crc of the byte stream and the results it implies
  class crc_tracker;
    logic [1:0]  width_code;
    logic [31:0] poly;
    logic [31:0] start_val;
    logic [31:0] xor_mask;
    logic        refl_in;
    logic        refl_out;
    logic [31:0] crc_state;
    crc_result_t expected_crcs[$];
    int          errors;

    function new();
      width_code = cce_pkg::RESET_WIDTH_CODE;
      poly       = cce_pkg::RESET_POLY;
      start_val  = cce_pkg::RESET_START;
      xor_mask   = cce_pkg::RESET_XOR;
      refl_in    = cce_pkg::RESET_REFLECT_IN;
      refl_out   = cce_pkg::RESET_REFLECT_OUT;
      crc_state  = 32'hFFFF_FFFF;
      errors     = 0;
    endfunction

    // reverse the low n bits of v
    function logic [31:0] mirror(logic [31:0] v, int unsigned n);
      logic [31:0] r;
      r = 32'd0;
      for (int i = 0; i < n; i++) begin
        r[i] = v[n-1-i];
      end
      return r;
    endfunction

    function void write_reg(logic [cce_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
      case (idx)
        cce_pkg::REG_WIDTH_CODE:   width_code = val[1:0];
        cce_pkg::REG_POLY_VALUE:   poly = val;
        cce_pkg::REG_START_VALUE:  start_val = val;
        cce_pkg::REG_OUT_XOR_MASK: xor_mask = val;
        cce_pkg::REG_REFLECT_IN:   refl_in = val[0];
        cce_pkg::REG_REFLECT_OUT:  refl_out = val[0];
        default: ;
      endcase
    endfunction

    // fold one accepted byte and queue the finished crc
    function void note_byte(logic [7:0] d, logic f, logic l);
      int unsigned w;
      logic [31:0] m;
      logic [31:0] t;
      logic [31:0] p;
      logic [31:0] r;
      logic [31:0] b;
      crc_result_t e;
      w = (width_code == cce_pkg::WIDTH_8) ? 8 :
          (width_code == cce_pkg::WIDTH_16) ? 16 : 32;
      m = 32'hFFFF_FFFF >> (32 - w);
      t = 32'd1 << (w - 1);
      p = poly & m;
      if (f) crc_state = start_val;
      r = crc_state & m;
      b = refl_in ? mirror({24'd0, d}, 8) : {24'd0, d};
      r = r ^ (b << (w - 8));
      for (int i = 0; i < 8; i++) begin
        r = ((r & t) != 0) ? (((r << 1) ^ p) & m) : ((r << 1) & m);
      end
      crc_state = r;
      if (refl_out) r = mirror(r, w);
      e.crc  = (r ^ xor_mask) & m;
      e.mark = l;
      expected_crcs.push_back(e);
    endfunction

    function void check_result(logic [31:0] crc, logic mark);
      crc_result_t e;
      if (expected_crcs.size() == 0) begin
        $error("unexpected result: crc_out %h final_mark %b", crc, mark);
        errors++;
        return;
      end
      e = expected_crcs.pop_front();
      if (crc !== e.crc) begin
        $error("crc_out mismatch: expected %h, actual %h", e.crc, crc);
        errors++;
      end
      if (mark !== e.mark) begin
        $error("final_mark mismatch: expected %b, actual %b", e.mark, mark);
        errors++;
      end
    endfunction

    function int pending();
      return expected_crcs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_crc_out;
  logic        out_final_mark;
  logic        cfg_we = 1'b0;
  logic [cce_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = 32'd0;

  crc_tracker  sb;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  int          quiet_cycles = 0;

  configurable_crc_engine_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_first_byte  (in_first_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_crc_out    (out_crc_out),
    .out_final_mark (out_final_mark),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // result transfer check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_crc_out, out_final_mark);
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req  <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // one byte transfer, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_first_byte <= f;
    in_last_byte  <= l;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_byte(d, f, l);
  endtask

  // stop offering and wait for every result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // single register write; the caller lowers cfg_we after a burst
  task automatic write_reg(input logic [cce_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // full setup; narrow registers get random upper bits
  task automatic apply_setting(input logic [1:0] code, input logic [31:0] poly,
                               input logic [31:0] start_val, input logic [31:0] xmask,
                               input logic rin, input logic rout, input bit junk);
    write_reg(cce_pkg::REG_WIDTH_CODE, ($urandom() & ~32'h3) | code);
    write_reg(cce_pkg::REG_POLY_VALUE, poly);
    write_reg(cce_pkg::REG_START_VALUE, start_val);
    write_reg(cce_pkg::REG_OUT_XOR_MASK, xmask);
    write_reg(cce_pkg::REG_REFLECT_IN, ($urandom() & ~32'h1) | rin);
    write_reg(cce_pkg::REG_REFLECT_OUT, ($urandom() & ~32'h1) | rout);
    if (junk) begin
      write_reg(REG_UNUSED_A, $urandom());
      write_reg(REG_UNUSED_B, $urandom());
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h0000_0000;
      1: v = 32'hFFFF_FFFF;
      2: v = 32'h04C1_1DB7;
      3: v = 32'h0000_1021;
      4: v = 32'h0000_8005;
      5: v = ($urandom_range(0, 1) != 0) ? 32'h0000_0031 : 32'h0000_0007;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0: v = 8'h00;
      1: v = 8'hFF;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  // messages with first/last framing, some bytes with random flags
  task automatic send_messages(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (int i = 0; i < len && sent < count; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_byte(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          send_byte(pick_byte(), i == 0, i == len - 1);
        end
        sent++;
      end
    end
  endtask

  initial begin : main
    int send_modes[4];
    int stall_modes[4];
    send_modes  = '{0, 53, 0, 35};
    stall_modes = '{0, 0, 53, 35};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup; the opening byte has no first flag and folds onto the reset value
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h31, 1'b1, 1'b0);
    send_byte(8'h32, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);
    drain();

    // plain crc-8, plus writes past the register list
    apply_setting(cce_pkg::WIDTH_8, 32'h0000_0007, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    drain();

    // reflected crc-16
    apply_setting(cce_pkg::WIDTH_16, 32'h0000_8005, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0);
    send_byte(8'h31, 1'b1, 1'b0);
    send_byte(8'h32, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b1);
    drain();

    // unused width code acts as 32 bits
    apply_setting(2'd3, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    drain();

    // width changed in the middle of a message
    apply_setting(cce_pkg::WIDTH_32, 32'h04C1_1DB7, 32'h1234_5678, 32'h0,
                  1'b0, 1'b0, 1'b0);
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    drain();
    write_reg(cce_pkg::REG_WIDTH_CODE, {30'd0, cce_pkg::WIDTH_8});
    cfg_we <= 1'b0;
    send_byte(8'h56, 1'b0, 1'b0);
    send_byte(8'h78, 1'b0, 1'b1);
    drain();
    write_reg(cce_pkg::REG_WIDTH_CODE, {30'd0, cce_pkg::WIDTH_16});
    cfg_we <= 1'b0;
    send_byte(8'h9A, 1'b0, 1'b0);
    drain();

    // zero polynomial
    apply_setting(cce_pkg::WIDTH_16, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  1'b1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    drain();

    // random part: four idle modes, several settings each
    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct = send_modes[mode];
      stall_pct     = stall_modes[mode];
      for (int s = 0; s < 7; s++) begin
        drain();
        apply_setting(2'($urandom_range(0, 3)), pick_word(), pick_word(), pick_word(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0);
        if (mode == 0 && s == 1) begin
          // long receiver hold-off while bytes keep coming
          hold_req <= 1'b1;
        end
        send_messages(ITEMS_PER_SET);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
